/* rtl/core/assert_macros.svh */
// Assertion macros shared by the receiver core.
// With SYNTH defined the macros expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checked at every rising edge except while reset is held.
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);
// Checked at every rising edge, reset included.
`define ASSERT_CLK(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg)
`define ASSERT_CLK(label, clk, prop, msg)
`endif
`endif

/* rtl/core/srr_pkg.sv */
`timescale 1ns / 1ps

package srr_pkg;

    localparam int BUFFER_DEPTH_DEF = 32;
    localparam int SEQ_W            = 16;
    localparam int WIN_W            = 6;
    localparam int SUM_W            = 32;
    localparam int PAYLOAD_BYTES    = 20;
    localparam int PAYLOAD_W        = PAYLOAD_BYTES * 8;
    localparam int BYTES_PER_WORD   = SUM_W / 8;
    localparam int WORD_CHUNKS      = PAYLOAD_BYTES / BYTES_PER_WORD;
    localparam int CHUNK_W          = $clog2(WORD_CHUNKS);
    // Wide enough for a slot index at a buffer depth of up to 64.
    localparam int SLOT_FIELD_W     = 6;

    localparam logic [SEQ_W-1:0] SEQ_MAX      = {SEQ_W{1'b1}};
    localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(8);

    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_SUM     = 5'b00010,
        S_CHECK   = 5'b00100,
        S_DELIVER = 5'b01000,
        S_WALK    = 5'b10000
    } t_state;

    typedef struct packed {
        logic                    set;
        logic                    clear;
        logic [SLOT_FIELD_W-1:0] slot;
    } t_flag_cmd;

    function automatic logic [SUM_W-1:0] sext_byte(input logic [7:0] b);
        return {{(SUM_W - 8){b[7]}}, b};
    endfunction

endpackage

/* rtl/core/selective_repeat_receiver_core.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Channel   Direction  Handshake                       Word
// packet    in         start high while busy low       seq, ack, checksum, payload
// result    out        o_result_valid for one cycle    result_kind
// config    in         i_cfg_valid and o_cfg_ready     window_size
//
// After a packet is taken the block is busy: the checksum adder folds four
// payload bytes a cycle over the five payload words, then the check step tests
// sum and window. An in-order packet adds a deliver step and a walk that releases
// the buffered packets (at most BUFFER_DEPTH - 1), one hold flag a cycle.
// Synchronous reset zeroes the expected number, clears the flags and returns
// the window to eight.
// Results cannot be held off, so nothing ever stalls inside the block.

module selective_repeat_receiver_core import srr_pkg::*; #(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [SEQ_W-1:0]        i_seq_number,
    input  logic [SEQ_W-1:0]        i_ack_number,
    input  logic signed [SUM_W-1:0] i_checksum_value,
    input  logic [63:0]             i_payload_low,
    input  logic [63:0]             i_payload_mid,
    input  logic [31:0]             i_payload_high,
    output logic                    o_result_valid,
    output logic                    o_result_kind,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [WIN_W-1:0]        i_window_size
);

    localparam int SLOT_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(BUFFER_DEPTH - 1);
    localparam logic [SLOT_W-1:0] STEPS_MAX = SLOT_W'(BUFFER_DEPTH - 1);
    localparam logic [SLOT_W:0]   DEPTH_S   = (SLOT_W + 1)'(BUFFER_DEPTH);
    localparam logic [WIN_W:0]    DEPTH_W   = (WIN_W + 1)'(BUFFER_DEPTH);
    localparam logic [CHUNK_W-1:0] LAST_CHUNK = CHUNK_W'(WORD_CHUNKS - 1);

    t_state               r_state;
    t_state               n_state;
    logic [WIN_W-1:0]     r_window;
    logic [SEQ_W-1:0]     r_exp;
    logic [SEQ_W-1:0]     n_exp;
    logic [SLOT_W-1:0]    r_slot;
    logic [SLOT_W-1:0]    n_slot;
    logic [SLOT_W-1:0]    r_steps;
    logic [SLOT_W-1:0]    n_steps;
    logic [CHUNK_W-1:0]   r_chunk;
    logic [CHUNK_W-1:0]   n_chunk;
    logic                 r_out_valid;
    logic                 n_out_valid;
    logic                 r_out_kind;
    logic                 n_out_kind;
    logic [SEQ_W-1:0]     r_seq;
    logic [SUM_W-1:0]     r_csum;
    logic [PAYLOAD_W-1:0] r_payload;

    logic                 accept;
    logic [SUM_W-1:0]     sum;
    logic [SUM_W-1:0]     chunk_word;
    logic                 held;
    t_flag_cmd            flag_cmd;

    logic [WIN_W:0]       win_eff;
    logic [SEQ_W:0]       exp_x;
    logic [SEQ_W:0]       seq_x;
    logic [SEQ_W:0]       win_x;
    logic [SEQ_W:0]       lower;
    logic [SEQ_W:0]       upper;
    logic                 good;
    logic [SEQ_W-1:0]     ahead;
    logic [SLOT_W:0]      slot_sum;
    logic [SLOT_W-1:0]    buf_slot;
    logic [SLOT_W-1:0]    slot_inc;
    logic                 walk_go;

    assign accept      = start && (r_state == S_IDLE);
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);

    assign chunk_word = r_payload[r_chunk * SUM_W +: SUM_W];

    srr_sum_unit u_sum (
        .i_clk  (i_clk),
        .i_load (accept),
        .i_seq  (i_seq_number),
        .i_ack  (i_ack_number),
        .i_add  (r_state == S_SUM),
        .i_word (chunk_word),
        .o_sum  (sum)
    );

    srr_flag_store #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_flags (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (flag_cmd),
        .o_held  (held)
    );

    // A window of zero acts as one; anything above the buffer depth is clipped.
    always_comb begin
        if (r_window == '0) begin
            win_eff = (WIN_W + 1)'(1);
        end else if ({1'b0, r_window} > DEPTH_W) begin
            win_eff = DEPTH_W;
        end else begin
            win_eff = {1'b0, r_window};
        end
    end

    assign exp_x = {1'b0, r_exp};
    assign seq_x = {1'b0, r_seq};
    assign win_x = (SEQ_W + 1)'(win_eff);
    assign lower = (exp_x >= win_x) ? (exp_x - win_x) : '0;
    assign upper = exp_x + win_x - (SEQ_W + 1)'(1);
    assign good  = (sum == r_csum) && (seq_x >= lower) && (seq_x <= upper);

    // A later packet lies less than one window ahead, so its slot is the
    // expected slot plus the distance, folded back once past the depth.
    assign ahead    = r_seq - r_exp;
    assign slot_sum = {1'b0, r_slot} + ahead[SLOT_W:0];
    assign buf_slot = (slot_sum >= DEPTH_S) ? SLOT_W'(slot_sum - DEPTH_S)
                                            : slot_sum[SLOT_W-1:0];
    assign slot_inc = (r_slot == LAST_SLOT) ? '0 : r_slot + SLOT_W'(1);

    assign walk_go = (r_steps < STEPS_MAX) && (r_exp != r_seq) && held;

    always_comb begin
        n_state        = r_state;
        n_exp          = r_exp;
        n_slot         = r_slot;
        n_steps        = r_steps;
        n_chunk        = r_chunk;
        n_out_valid    = 1'b0;
        n_out_kind     = r_out_kind;
        flag_cmd.set   = 1'b0;
        flag_cmd.clear = 1'b0;
        flag_cmd.slot  = SLOT_FIELD_W'(r_slot);
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_chunk = '0;
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                n_chunk = r_chunk + CHUNK_W'(1);
                if (r_chunk == LAST_CHUNK) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_state = S_IDLE;
                flag_cmd.slot = SLOT_FIELD_W'(buf_slot);
                if (good) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_ACK;
                    if (r_seq == r_exp) begin
                        n_state = S_DELIVER;
                    end else if (r_seq > r_exp) begin
                        flag_cmd.set = 1'b1;
                    end
                end
            end
            S_DELIVER: begin
                n_out_valid = 1'b1;
                n_out_kind  = KIND_DATA;
                n_steps     = '0;
                if (r_exp != SEQ_MAX) begin
                    n_exp  = r_exp + SEQ_W'(1);
                    n_slot = slot_inc;
                end
                n_state = S_WALK;
            end
            S_WALK: begin
                if (walk_go) begin
                    flag_cmd.clear = 1'b1;
                    n_out_valid    = 1'b1;
                    n_out_kind     = KIND_DATA;
                    n_steps        = r_steps + SLOT_W'(1);
                    if (r_exp == SEQ_MAX) begin
                        // Saturated counter: this delivery ends the walk.
                        n_state = S_IDLE;
                    end else begin
                        n_exp  = r_exp + SEQ_W'(1);
                        n_slot = slot_inc;
                    end
                end else begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_window    <= WINDOW_RESET;
            r_exp       <= '0;
            r_slot      <= '0;
            r_steps     <= '0;
            r_chunk     <= '0;
            r_out_valid <= 1'b0;
            r_out_kind  <= KIND_ACK;
        end else begin
            r_state     <= n_state;
            r_exp       <= n_exp;
            r_slot      <= n_slot;
            r_steps     <= n_steps;
            r_chunk     <= n_chunk;
            r_out_valid <= n_out_valid;
            r_out_kind  <= n_out_kind;
            if (i_cfg_valid && o_cfg_ready) begin
                r_window <= i_window_size;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_seq     <= i_seq_number;
            r_csum    <= $unsigned(i_checksum_value);
            r_payload <= {i_payload_high, i_payload_mid, i_payload_low};
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_result_kind  = r_out_kind;

    `ASSERT_CLK(a_reset_quiet, i_clk, !i_rst_n |=> (!o_result_valid && !busy), "reset left the core active")
    `ASSERT_CLK_RST(a_ack_after_check, i_clk, i_rst_n, (o_result_valid && (o_result_kind == KIND_ACK)) |-> $past(r_state == S_CHECK), "ACK word outside the check step")
    `ASSERT_CLK_RST(a_data_after_ack, i_clk, i_rst_n, (o_result_valid && (o_result_kind == KIND_DATA)) |-> ($past(r_state == S_DELIVER) || $past(r_state == S_WALK)), "delivery word outside the walk")
    `ASSERT_CLK_RST(a_exp_monotonic, i_clk, i_rst_n, $past(i_rst_n) |-> (r_exp >= $past(r_exp)), "expected number went backwards")
    `ASSERT_CLK_RST(a_walk_bound, i_clk, i_rst_n, r_steps <= STEPS_MAX, "walk ran past the buffer depth")

endmodule

/* rtl/core/srr_sum_unit.sv */
`timescale 1ns / 1ps

module srr_sum_unit import srr_pkg::*; (
    input  logic             i_clk,
    input  logic             i_load,
    input  logic [SEQ_W-1:0] i_seq,
    input  logic [SEQ_W-1:0] i_ack,
    input  logic             i_add,
    input  logic [SUM_W-1:0] i_word,
    output logic [SUM_W-1:0] o_sum
);

    logic [SUM_W-1:0] r_acc;
    logic [SUM_W-1:0] n_acc;
    logic [SUM_W-1:0] word_sum;

    // Four payload bytes, each taken as a signed value, join the running sum.
    always_comb begin
        word_sum = r_acc;
        for (int k = 0; k < BYTES_PER_WORD; k++) begin
            word_sum = word_sum + sext_byte(i_word[8*k +: 8]);
        end
    end

    always_comb begin
        n_acc = r_acc;
        if (i_load) begin
            n_acc = SUM_W'(i_seq) + SUM_W'(i_ack);
        end else if (i_add) begin
            n_acc = word_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_sum = r_acc;

endmodule

/* rtl/core/srr_flag_store.sv */
`timescale 1ns / 1ps

module srr_flag_store import srr_pkg::*; #(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_flag_cmd i_cmd,
    output logic      o_held
);

    localparam int SLOT_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

    logic [BUFFER_DEPTH-1:0] r_held;
    logic [SLOT_W-1:0]       idx;

    assign idx    = i_cmd.slot[SLOT_W-1:0];
    assign o_held = r_held[idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (i_cmd.set) begin
            r_held[idx] <= 1'b1;
        end else if (i_cmd.clear) begin
            r_held[idx] <= 1'b0;
        end
    end

endmodule
